### hw/rtl/lph_pkg.sv
package lph_pkg;

   // field widths of the request and response transfers
   localparam int KEY_W     = 14;
   localparam int PAYLOAD_W = 64;
   localparam int SLOT_W    = 7;
   localparam int STATUS_W  = 2;

   // accepted key range
   localparam logic [KEY_W-1:0] KEY_MIN = 14'd1000;
   localparam logic [KEY_W-1:0] KEY_MAX = 14'd9999;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   // controller states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_PROBE,
      ST_READ,
      ST_RESULT
   } state_type;

endpackage

### hw/rtl/lph_ram.sv
// Simple dual-port RAM: one write port, one read port, registered read data.
module lph_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                    wr_data,
   input  logic                                rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                    rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/linear_probe_hash_insert.sv
// Open-addressing hash table with linear probing over TABLE_SIZE slots. An insert
// (action 0) with a key from 1000 to 9999 stores key and payload in the first empty
// slot at or after key mod TABLE_SIZE, wrapping to slot 0, and answers with that
// slot; other keys answer status 1, and a table with no empty slot answers status 2
// with nothing written. A read (action 1) returns key and payload of one slot; key
// 0 means empty, and the payload of a slot never written is undefined. Keys and
// payloads live in two RAMs with one read port each and registered read data, and the
// probe walks the key RAM one read per cycle; the next request is taken once the
// response is registered. After reset the key RAM is cleared, one slot per cycle,
// and no request is taken until every slot has been cleared.
module linear_probe_hash_insert
   import lph_pkg::*;
#(
   parameter int TABLE_SIZE = 128
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_action,
   input  logic [KEY_W-1:0]     req_key,
   input  logic [PAYLOAD_W-1:0] req_payload,
   input  logic [SLOT_W-1:0]    req_read_slot,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [SLOT_W-1:0]    rsp_slot_index,
   output logic [KEY_W-1:0]     rsp_slot_key,
   output logic [PAYLOAD_W-1:0] rsp_slot_payload
);

   localparam int IDX_W  = $clog2(TABLE_SIZE);
   localparam int PROD_W = 2 * KEY_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);
   localparam logic [KEY_W-1:0] SIZE_K   = KEY_W'(TABLE_SIZE);
   // floor(2^KEY_W / TABLE_SIZE): quotient estimate is exact or one low
   localparam logic [KEY_W-1:0] RECIP_K  = KEY_W'((1 << KEY_W) / TABLE_SIZE);

   state_type state_ff, state_in;

   logic [IDX_W-1:0]     clr_ff, clr_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [PAYLOAD_W-1:0] payload_ff, payload_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [IDX_W-1:0]     probe_ff, probe_in;
   logic [IDX_W-1:0]     count_ff, count_in;
   logic [STATUS_W-1:0]  res_status_ff, res_status_in;
   logic [SLOT_W-1:0]    res_slot_ff, res_slot_in;
   logic [KEY_W-1:0]     res_key_ff, res_key_in;
   logic [PAYLOAD_W-1:0] res_payload_ff, res_payload_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [SLOT_W-1:0]    rsp_slot_ff;
   logic [KEY_W-1:0]     rsp_key_ff;
   logic [PAYLOAD_W-1:0] rsp_payload_ff;
   logic                 rsp_load;

   // RAM ports
   logic                 key_wr_en, key_rd_en;
   logic [IDX_W-1:0]     key_wr_addr, ram_rd_addr;
   logic [KEY_W-1:0]     key_wr_data, key_rd_data;
   logic                 pay_wr_en;
   logic [PAYLOAD_W-1:0] pay_rd_data;

   // decisions
   logic                 req_xfer;
   logic                 key_in_range;
   logic                 slot_in_table;
   logic [IDX_W-1:0]     req_slot_idx;
   logic                 probe_empty;
   logic                 probe_last;
   logic                 rsp_free;
   logic [IDX_W-1:0]     next_probe;

   // home slot: key - q * TABLE_SIZE, then one correction
   logic [KEY_W-1:0]     quot;
   logic [PROD_W-1:0]    quot_size;
   logic [KEY_W-1:0]     rem_est;
   logic [KEY_W-1:0]     rem;
   logic [IDX_W-1:0]     home;

   assign quot      = prod_ff[PROD_W-1:KEY_W];
   assign quot_size = PROD_W'(quot) * PROD_W'(SIZE_K);
   assign rem_est   = key_ff - quot_size[KEY_W-1:0];
   assign rem       = (rem_est >= SIZE_K) ? (rem_est - SIZE_K) : rem_est;
   assign home      = IDX_W'(rem);

   assign req_xfer      = req_valid && (state_ff == ST_IDLE);
   assign key_in_range  = (req_key >= KEY_MIN) && (req_key <= KEY_MAX);
   assign slot_in_table = (32'(req_read_slot) < TABLE_SIZE);
   assign req_slot_idx  = IDX_W'(req_read_slot);
   assign probe_empty   = (key_rd_data == '0);
   assign probe_last    = (count_ff == LAST_IDX);
   assign rsp_free      = !rsp_valid_ff || !rsp_stall;
   assign next_probe    = (probe_ff == LAST_IDX) ? '0 : probe_ff + 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_action) begin
                  state_in = slot_in_table ? ST_READ : ST_RESULT;
               end else begin
                  state_in = key_in_range ? ST_HASH : ST_RESULT;
               end
            end
         end
         ST_HASH: begin
            state_in = ST_PROBE;
         end
         ST_PROBE: begin
            if (probe_empty || probe_last) begin
               state_in = ST_RESULT;
            end
         end
         ST_READ: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // outputs and datapath next values
   always_comb begin
      req_stall      = (state_ff != ST_IDLE);
      clr_in         = clr_ff;
      key_in         = key_ff;
      payload_in     = payload_ff;
      prod_in        = prod_ff;
      probe_in       = probe_ff;
      count_in       = count_ff;
      res_status_in  = res_status_ff;
      res_slot_in    = res_slot_ff;
      res_key_in     = res_key_ff;
      res_payload_in = res_payload_ff;
      key_wr_en      = 1'b0;
      key_wr_addr    = probe_ff;
      key_wr_data    = key_ff;
      pay_wr_en      = 1'b0;
      key_rd_en      = 1'b0;
      ram_rd_addr    = next_probe;
      rsp_load       = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            key_wr_en   = 1'b1;
            key_wr_addr = clr_ff;
            key_wr_data = '0;
            clr_in      = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (req_xfer) begin
               key_in         = req_key;
               payload_in     = req_payload;
               prod_in        = PROD_W'(req_key) * PROD_W'(RECIP_K);
               res_status_in  = STATUS_OK;
               res_slot_in    = '0;
               res_key_in     = '0;
               res_payload_in = '0;
               if (req_action) begin
                  res_slot_in = req_read_slot;
                  key_rd_en   = slot_in_table;
                  ram_rd_addr = req_slot_idx;
               end else if (!key_in_range) begin
                  res_status_in = STATUS_RANGE;
               end
            end
         end
         ST_HASH: begin
            key_rd_en   = 1'b1;
            ram_rd_addr = home;
            probe_in    = home;
            count_in    = '0;
         end
         ST_PROBE: begin
            if (probe_empty) begin
               key_wr_en      = 1'b1;
               pay_wr_en      = 1'b1;
               res_status_in  = STATUS_OK;
               res_slot_in    = SLOT_W'(probe_ff);
               res_key_in     = key_ff;
               res_payload_in = payload_ff;
            end else if (probe_last) begin
               res_status_in  = STATUS_FULL;
               res_slot_in    = '0;
               res_key_in     = '0;
               res_payload_in = '0;
            end else begin
               key_rd_en = 1'b1;
               probe_in  = next_probe;
               count_in  = count_ff + 1'b1;
            end
         end
         ST_READ: begin
            res_key_in     = key_rd_data;
            res_payload_in = pay_rd_data;
         end
         ST_RESULT: begin
            rsp_load = rsp_free;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      key_ff         <= key_in;
      payload_ff     <= payload_in;
      prod_ff        <= prod_in;
      probe_ff       <= probe_in;
      count_ff       <= count_in;
      res_status_ff  <= res_status_in;
      res_slot_ff    <= res_slot_in;
      res_key_ff     <= res_key_in;
      res_payload_ff <= res_payload_in;
      if (rsp_load) begin
         rsp_status_ff  <= res_status_ff;
         rsp_slot_ff    <= res_slot_ff;
         rsp_key_ff     <= res_key_ff;
         rsp_payload_ff <= res_payload_ff;
      end
   end

   // key store, cleared after reset
   lph_ram #(
      .WIDTH (KEY_W),
      .DEPTH (TABLE_SIZE)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (key_wr_addr),
      .wr_data (key_wr_data),
      .rd_en   (key_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (key_rd_data)
   );

   // payload store, written only by inserts
   lph_ram #(
      .WIDTH (PAYLOAD_W),
      .DEPTH (TABLE_SIZE)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (pay_wr_en),
      .wr_addr (probe_ff),
      .wr_data (payload_ff),
      .rd_en   (key_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (pay_rd_data)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_slot_index   = rsp_slot_ff;
   assign rsp_slot_key     = rsp_key_ff;
   assign rsp_slot_payload = rsp_payload_ff;

endmodule
